[src/cpfq_pkg.sv]
package cpfq_pkg;

	localparam int QUEUE_SLOTS_DEF = 16;
	localparam int MAX_POP_DEF     = 16;
	localparam int RESULT_CAP      = 16;
	localparam int NUM_COUNTERS    = 7;
	localparam int CFG_DATA_W      = 16;
	localparam int LIMIT_W         = 5;
	localparam logic [3:0] FRAME_DLC = 4'd8;

	typedef enum logic [1:0] {
		CMD_FRAME,
		CMD_POP,
		CMD_SNAP,
		CMD_STAT
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ENABLE,
		REG_RX_BUS,
		REG_RX_ID,
		REG_TIMEOUT
	} reg_idx_t;

	typedef enum logic [2:0] {
		CNT_TYPE,
		CNT_BUS,
		CNT_ID,
		CNT_DLC,
		CNT_VALID,
		CNT_DROP,
		CNT_QUEUED
	} cnt_idx_t;

	typedef enum logic [2:0] {
		OP_ACCEPT,
		OP_REJ_TYPE,
		OP_REJ_BUS,
		OP_REJ_ID,
		OP_REJ_DLC,
		OP_POP,
		OP_SNAP,
		OP_STAT
	} op_t;

	typedef struct packed {
		logic        meter_enable;
		logic [1:0]  rx_bus;
		logic [10:0] rx_id;
		logic [15:0] fresh_timeout;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [1:0]         bus;
		logic [10:0]        std_id;
		logic [3:0]         dlc;
		logic [7:0]         frame_flags;
		logic [31:0]        payload;
		logic [31:0]        time_ms;
		logic [LIMIT_W-1:0] pop_limit;
		logic [2:0]         stat_index;
	} req_t;

	typedef struct packed {
		logic [15:0] raw_voltage;
		logic [15:0] raw_current;
		logic [31:0] power_raw;
		logic [31:0] sample_time;
		logic [31:0] sequence_res;
		logic        fresh;
		logic        sample_valid;
		logic [31:0] stat_value;
		logic        last;
	} res_t;

	typedef struct packed {
		op_t                op;
		logic [31:0]        payload;
		logic [31:0]        time_ms;
		logic [LIMIT_W-1:0] pop_limit;
		logic [2:0]         stat_index;
	} job_t;

	function automatic logic cfg_active(cfg_t c);
		return c.meter_enable && (c.rx_bus != 2'd0) && (c.fresh_timeout != 16'd0);
	endfunction

	function automatic logic [31:0] meas_power(logic [31:0] meas);
		return {16'd0, meas[15:0]} * {16'd0, meas[31:16]};
	endfunction

endpackage

[src/cpfq_stream_if.sv]
interface cpfq_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/cpfq_ram.sv]
module cpfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/cpfq_front.sv]
module cpfq_front import cpfq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	cpfq_stream_if.sink     request,
	output logic            job_valid,
	output job_t            job,
	input  logic            job_ready
);

	job_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	job_t       job_new;
	logic       take;
	logic       push;
	logic       pop;

	// classify the incoming item
	always_comb begin
		job_new.payload    = request.data.payload;
		job_new.time_ms    = request.data.time_ms;
		job_new.pop_limit  = request.data.pop_limit;
		job_new.stat_index = request.data.stat_index;
		case (cmd_t'(request.data.cmd))
			CMD_FRAME: begin
				if (request.data.frame_flags != 8'd0) begin
					job_new.op = OP_REJ_TYPE;
				end else if (request.data.bus != cfg.rx_bus) begin
					job_new.op = OP_REJ_BUS;
				end else if (request.data.std_id != cfg.rx_id) begin
					job_new.op = OP_REJ_ID;
				end else if (request.data.dlc != FRAME_DLC) begin
					job_new.op = OP_REJ_DLC;
				end else begin
					job_new.op = OP_ACCEPT;
				end
			end
			CMD_POP:  job_new.op = OP_POP;
			CMD_SNAP: job_new.op = OP_SNAP;
			default:  job_new.op = OP_STAT;
		endcase
	end

	assign request.ready = (fill_q != 2'd2);
	assign take          = request.valid && request.ready;
	// frames seen while inactive vanish here
	assign push          = take && !((cmd_t'(request.data.cmd) == CMD_FRAME) && !cfg_active(cfg));
	assign job_valid     = (fill_q != 2'd0);
	assign job           = fifo_q[rd_ptr_q];
	assign pop           = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= job_new;
		end
	end

endmodule

[src/cpfq_back.sv]
module cpfq_back import cpfq_pkg::*; #(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
	parameter int MAX_POP     = MAX_POP_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            job_valid,
	input  job_t            job,
	output logic            job_ready,
	cpfq_stream_if.source   result
);

	localparam int PTR_W   = $clog2(QUEUE_SLOTS);
	localparam int POP_CAP = (MAX_POP < RESULT_CAP) ? MAX_POP : RESULT_CAP;
	localparam int SLOT_W  = 96;
	localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);
	localparam logic [LIMIT_W-1:0] CAP_LIM   = LIMIT_W'(POP_CAP);

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [31:0]        snap_meas_q;
	logic [31:0]        snap_time_q;
	logic [31:0]        snap_seq_q;
	logic [31:0]        counters_q [NUM_COUNTERS];
	logic [LIMIT_W-1:0] limit_q;
	logic [LIMIT_W-1:0] cnt_q;
	res_t               out_q;
	logic               out_vld_q;

	logic [PTR_W-1:0]   head_next;
	logic [PTR_W-1:0]   tail_next;
	logic               q_empty;
	logic               q_full;
	logic [LIMIT_W-1:0] limit_in;
	logic [31:0]        valid_next;
	logic [31:0]        age;
	logic               fresh;
	logic               out_free;
	logic               frame_op;
	logic               job_take;
	logic               start_pop;
	logic               emit_samp;
	logic               samp_last;
	logic               ram_we;
	logic               ram_re;
	logic [PTR_W-1:0]   ram_raddr;
	logic [SLOT_W-1:0]  ram_wdata;
	logic [SLOT_W-1:0]  ram_rdata;
	logic               out_load;
	res_t               out_new;

	cpfq_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (QUEUE_SLOTS)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign head_next  = (head_q == LAST_SLOT) ? '0 : head_q + PTR_W'(1);
	assign tail_next  = (tail_q == LAST_SLOT) ? '0 : tail_q + PTR_W'(1);
	assign q_empty    = (head_q == tail_q);
	assign q_full     = (head_next == tail_q);
	assign limit_in   = (job.pop_limit > CAP_LIM) ? CAP_LIM : job.pop_limit;
	assign valid_next = counters_q[CNT_VALID] + 32'd1;
	assign age        = job.time_ms - snap_time_q;
	assign fresh      = cfg_active(cfg) && (snap_seq_q != 32'd0)
		&& (age <= {16'd0, cfg.fresh_timeout});
	assign out_free   = !out_vld_q || result.ready;
	assign frame_op   = (job.op == OP_ACCEPT) || (job.op == OP_REJ_TYPE)
		|| (job.op == OP_REJ_BUS) || (job.op == OP_REJ_ID) || (job.op == OP_REJ_DLC);
	assign job_ready  = (state_q == ST_IDLE) && (frame_op || out_free);
	assign job_take   = job_valid && job_ready;
	assign start_pop  = job_take && (job.op == OP_POP) && (limit_in != '0) && !q_empty;
	assign emit_samp  = (state_q == ST_POP) && out_free;
	assign samp_last  = ((cnt_q + LIMIT_W'(1)) == limit_q) || (tail_next == head_q);
	assign ram_we     = job_take && (job.op == OP_ACCEPT) && !q_full;
	assign ram_wdata  = {valid_next, job.time_ms, job.payload};
	assign ram_re     = start_pop || (emit_samp && !samp_last);
	assign ram_raddr  = (state_q == ST_POP) ? tail_next : tail_q;

	always_comb begin
		out_new  = '0;
		out_load = 1'b0;
		if (emit_samp) begin
			out_new.raw_voltage  = ram_rdata[15:0];
			out_new.raw_current  = ram_rdata[31:16];
			out_new.power_raw    = meas_power(ram_rdata[31:0]);
			out_new.sample_time  = ram_rdata[63:32];
			out_new.sequence_res = ram_rdata[95:64];
			out_new.sample_valid = 1'b1;
			out_new.last         = samp_last;
			out_load             = 1'b1;
		end else if (job_take) begin
			case (job.op)
				OP_POP: begin
					// nothing to pop: one empty result
					if (!start_pop) begin
						out_new.last = 1'b1;
						out_load     = 1'b1;
					end
				end
				OP_SNAP: begin
					out_new.raw_voltage  = snap_meas_q[15:0];
					out_new.raw_current  = snap_meas_q[31:16];
					out_new.power_raw    = meas_power(snap_meas_q);
					out_new.sample_time  = snap_time_q;
					out_new.sequence_res = snap_seq_q;
					out_new.fresh        = fresh;
					out_new.sample_valid = (snap_seq_q != 32'd0);
					out_new.last         = 1'b1;
					out_load             = 1'b1;
				end
				OP_STAT: begin
					out_new.stat_value = (job.stat_index < 3'(NUM_COUNTERS))
						? counters_q[job.stat_index] : 32'd0;
					out_new.last       = 1'b1;
					out_load           = 1'b1;
				end
				default: begin
					out_load = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			snap_meas_q <= '0;
			snap_time_q <= '0;
			snap_seq_q  <= '0;
			limit_q     <= '0;
			cnt_q       <= '0;
			out_vld_q   <= 1'b0;
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				counters_q[i] <= '0;
			end
		end else begin
			if (job_take) begin
				case (job.op)
					OP_REJ_TYPE: counters_q[CNT_TYPE] <= counters_q[CNT_TYPE] + 32'd1;
					OP_REJ_BUS:  counters_q[CNT_BUS]  <= counters_q[CNT_BUS] + 32'd1;
					OP_REJ_ID:   counters_q[CNT_ID]   <= counters_q[CNT_ID] + 32'd1;
					OP_REJ_DLC:  counters_q[CNT_DLC]  <= counters_q[CNT_DLC] + 32'd1;
					OP_ACCEPT: begin
						snap_meas_q           <= job.payload;
						snap_time_q           <= job.time_ms;
						snap_seq_q            <= valid_next;
						counters_q[CNT_VALID] <= valid_next;
						if (q_full) begin
							counters_q[CNT_DROP] <= counters_q[CNT_DROP] + 32'd1;
						end else begin
							head_q                 <= head_next;
							counters_q[CNT_QUEUED] <= counters_q[CNT_QUEUED] + 32'd1;
						end
					end
					OP_POP: begin
						if (start_pop) begin
							state_q <= ST_POP;
							limit_q <= limit_in;
							cnt_q   <= '0;
						end
					end
					default: begin
						state_q <= state_q;
					end
				endcase
			end
			if (emit_samp) begin
				tail_q <= tail_next;
				cnt_q  <= cnt_q + LIMIT_W'(1);
				if (samp_last) begin
					state_q <= ST_IDLE;
				end
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_new;
		end
	end

	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> (head_q != tail_q))
		else $error("pop in progress on an empty ring");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> (cnt_q < limit_q))
		else $error("pop ran past its limit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (head_next != tail_q))
		else $error("write into the reserved empty slot");

	a_tail_moves: assert property (@(posedge clk) disable iff (!arst_n)
		emit_samp |=> (tail_q != $past(tail_q)))
		else $error("sample sent without advancing tail");

endmodule

[src/can_power_frame_filter_queue.sv]
// CAN power meter frame filter and sample ring.
// request channel: one item per command (frame, pop, snapshot query, statistic read).
// result channel: the results of each item, the final one marked by last; frames
// give no result.
// config port: cfg_wen writes cfg_wdata into the register named by cfg_index
// (enable, bus, identifier, freshness timeout); write only while the block is idle.
// a two-entry command queue sits between the classifier and the executing back end,
// so the request side keeps going while a result waits at the output register.
// frame: classified on accept, held in the command queue, then applied to counters, snapshot and ring.
// query or statistic read: result registered in the output register once the back end takes the item.
// pop: first sample after a ring memory read, then one sample per cycle while the output
// register is free; an empty pop gives one empty result.
// sustained rate: one command per cycle in the back end while no pop is in progress and the output register is free.
// reset clears registers, counters, snapshot and ring pointers; ring contents are
// not cleared and need no clearing pass.
// when the receiver stalls the output register holds, the back end waits and the
// command queue absorbs up to two more items before request ready drops.
module can_power_frame_filter_queue import cpfq_pkg::*; #(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
	parameter int MAX_POP     = MAX_POP_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	cpfq_stream_if.sink           request,
	cpfq_stream_if.source         result
);

	cfg_t cfg_q;
	logic job_valid;
	logic job_ready;
	job_t job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLE:  cfg_q.meter_enable  <= cfg_wdata[0];
				REG_RX_BUS:  cfg_q.rx_bus        <= cfg_wdata[1:0];
				REG_RX_ID:   cfg_q.rx_id         <= cfg_wdata[10:0];
				REG_TIMEOUT: cfg_q.fresh_timeout <= cfg_wdata[15:0];
				default:     cfg_q               <= cfg_q;
			endcase
		end
	end

	cpfq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.request   (request),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready)
	);

	cpfq_back #(
		.QUEUE_SLOTS (QUEUE_SLOTS),
		.MAX_POP     (MAX_POP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready),
		.result    (result)
	);

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import cpfq_pkg::*;

	class meter_scoreboard;
		logic        en_reg;
		logic [1:0]  bus_reg;
		logic [10:0] id_reg;
		logic [15:0] tmo_reg;
		logic [31:0] ring_meas [QUEUE_SLOTS_DEF];
		logic [31:0] ring_time [QUEUE_SLOTS_DEF];
		logic [31:0] ring_seq [QUEUE_SLOTS_DEF];
		int          head;
		int          tail;
		logic [31:0] snap_meas;
		logic [31:0] snap_time;
		logic [31:0] snap_seq;
		logic [31:0] counts [NUM_COUNTERS];
		res_t        awaited_results [$];
		int          errors;
		int          checked;
		int          popped;
		int          ring_full_hits;
		int          fresh_hits;

		function new();
			en_reg = 1'b0;
			bus_reg = '0;
			id_reg = '0;
			tmo_reg = '0;
			head = 0;
			tail = 0;
			snap_meas = '0;
			snap_time = '0;
			snap_seq = '0;
			foreach (counts[i]) counts[i] = '0;
			errors = 0;
			checked = 0;
			popped = 0;
			ring_full_hits = 0;
			fresh_hits = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_ENABLE: en_reg = v[0];
				REG_RX_BUS: bus_reg = v[1:0];
				REG_RX_ID: id_reg = v[10:0];
				REG_TIMEOUT: tmo_reg = v[15:0];
				default: ;
			endcase
		endfunction

		function bit live();
			return en_reg && bus_reg != 2'd0 && tmo_reg != 16'd0;
		endfunction

		function res_t sample_res(logic [31:0] meas, logic [31:0] t, logic [31:0] seq);
			res_t        o;
			logic [31:0] v32;
			logic [31:0] c32;
			o = '0;
			v32 = meas & 32'h0000_FFFF;
			c32 = meas >> 16;
			o.raw_voltage = v32[15:0];
			o.raw_current = c32[15:0];
			o.power_raw = v32 * c32;
			o.sample_time = t;
			o.sequence_res = seq;
			return o;
		endfunction

		function void take_frame(req_t r);
			int nxt;
			if (!live())
				return;
			if (r.frame_flags != 8'd0) begin
				counts[CNT_TYPE]++;
			end else if (r.bus != bus_reg) begin
				counts[CNT_BUS]++;
			end else if (r.std_id != id_reg) begin
				counts[CNT_ID]++;
			end else if (r.dlc != FRAME_DLC) begin
				counts[CNT_DLC]++;
			end else begin
				snap_meas = r.payload;
				snap_time = r.time_ms;
				counts[CNT_VALID]++;
				snap_seq = counts[CNT_VALID];
				nxt = (head + 1) % QUEUE_SLOTS_DEF;
				if (nxt == tail) begin
					counts[CNT_DROP]++;
					ring_full_hits++;
				end else begin
					ring_meas[head] = snap_meas;
					ring_time[head] = snap_time;
					ring_seq[head] = snap_seq;
					head = nxt;
					counts[CNT_QUEUED]++;
				end
			end
		endfunction

		function void note_command(req_t r);
			res_t        o;
			int          lim;
			int          n;
			logic [31:0] age;
			case (r.cmd)
				CMD_FRAME: take_frame(r);
				CMD_POP: begin
					lim = (r.pop_limit > MAX_POP_DEF) ? MAX_POP_DEF : int'(r.pop_limit);
					n = 0;
					while (n < lim && tail != head) begin
						o = sample_res(ring_meas[tail], ring_time[tail], ring_seq[tail]);
						o.sample_valid = 1'b1;
						tail = (tail + 1) % QUEUE_SLOTS_DEF;
						n++;
						o.last = (n >= lim) || (tail == head);
						awaited_results.push_back(o);
					end
					if (n == 0) begin
						o = '0;
						o.last = 1'b1;
						awaited_results.push_back(o);
					end
					popped += n;
				end
				CMD_SNAP: begin
					age = r.time_ms - snap_time;
					o = sample_res(snap_meas, snap_time, snap_seq);
					o.sample_valid = (snap_seq != 32'd0);
					o.fresh = live() && snap_seq != 32'd0 && age <= {16'd0, tmo_reg};
					o.last = 1'b1;
					if (o.fresh)
						fresh_hits++;
					awaited_results.push_back(o);
				end
				default: begin
					o = '0;
					o.stat_value = (r.stat_index < NUM_COUNTERS) ? counts[r.stat_index] : 32'd0;
					o.last = 1'b1;
					awaited_results.push_back(o);
				end
			endcase
		endfunction

		function void check_result(res_t got);
			res_t  exp;
			string bad;
			checked++;
			if (awaited_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %0d: %p", checked, got);
				return;
			end
			exp = awaited_results.pop_front();
			bad = "";
			if (got.raw_voltage !== exp.raw_voltage) bad = {bad, " raw_voltage"};
			if (got.raw_current !== exp.raw_current) bad = {bad, " raw_current"};
			if (got.power_raw !== exp.power_raw) bad = {bad, " power_raw"};
			if (got.sample_time !== exp.sample_time) bad = {bad, " sample_time"};
			if (got.sequence_res !== exp.sequence_res) bad = {bad, " sequence_res"};
			if (got.fresh !== exp.fresh) bad = {bad, " fresh"};
			if (got.sample_valid !== exp.sample_valid) bad = {bad, " sample_valid"};
			if (got.stat_value !== exp.stat_value) bad = {bad, " stat_value"};
			if (got.last !== exp.last) bad = {bad, " last"};
			if (bad != "") begin
				errors++;
				if (errors <= 10) begin
					$display("result %0d mismatch in%s", checked, bad);
					$display("  expected %p", exp);
					$display("  actual   %p", got);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [1:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	cpfq_stream_if #(.T(req_t)) req_ch ();
	cpfq_stream_if #(.T(res_t)) res_ch ();

	meter_scoreboard sb = new();

	logic [31:0] now_ms = 32'd0;
	bit          tx_free = 1'b0;
	bit          rx_free = 1'b0;
	int          rx_hold = 0;
	int          settings_used = 0;
	int          items_sent = 0;

	can_power_frame_filter_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.request   (req_ch),
		.result    (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 92)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic int tx_gap();
		if (tx_free || $urandom_range(0, 99) < 55)
			return 0;
		return stall_len();
	endfunction

	always @(negedge clk) begin
		if (rx_free) begin
			res_ch.ready <= 1'b1;
		end else if (rx_hold > 0) begin
			res_ch.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if ($urandom_range(0, 99) < 15) begin
			res_ch.ready <= 1'b0;
			rx_hold <= stall_len() - 1;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// results are checked before the new item is noted
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.data);
		if (req_ch.valid && req_ch.ready)
			sb.note_command(req_ch.data);
	end

	function automatic req_t noise_item();
		req_t r;
		r.cmd = 2'($urandom_range(0, 3));
		r.bus = 2'($urandom_range(0, 3));
		r.std_id = 11'($urandom_range(0, 2047));
		r.dlc = 4'($urandom_range(0, 15));
		r.frame_flags = 8'($urandom_range(0, 255));
		r.payload = $urandom();
		r.time_ms = $urandom();
		r.pop_limit = LIMIT_W'($urandom_range(0, 31));
		r.stat_index = 3'($urandom_range(0, 7));
		return r;
	endfunction

	function automatic req_t frame_of(logic [7:0] flags, logic [1:0] bus, logic [10:0] id,
			logic [3:0] dlc, logic [31:0] payload, logic [31:0] t);
		req_t r;
		r = noise_item();
		r.cmd = CMD_FRAME;
		r.frame_flags = flags;
		r.bus = bus;
		r.std_id = id;
		r.dlc = dlc;
		r.payload = payload;
		r.time_ms = t;
		return r;
	endfunction

	function automatic req_t pop_of(logic [LIMIT_W-1:0] lim);
		req_t r;
		r = noise_item();
		r.cmd = CMD_POP;
		r.pop_limit = lim;
		return r;
	endfunction

	function automatic req_t snap_of(logic [31:0] t);
		req_t r;
		r = noise_item();
		r.cmd = CMD_SNAP;
		r.time_ms = t;
		return r;
	endfunction

	function automatic req_t stat_of(logic [2:0] idx);
		req_t r;
		r = noise_item();
		r.cmd = CMD_STAT;
		r.stat_index = idx;
		return r;
	endfunction

	function automatic req_t good_frame();
		now_ms = now_ms + $urandom_range(0, 40);
		return frame_of(8'd0, sb.bus_reg, sb.id_reg, FRAME_DLC, $urandom(), now_ms);
	endfunction

	function automatic req_t bad_frame();
		req_t r;
		int   d;
		r = good_frame();
		case ($urandom_range(0, 4))
			0: r.frame_flags = 8'($urandom_range(1, 255));
			1: r.bus = r.bus ^ 2'($urandom_range(1, 3));
			2: r.std_id = r.std_id ^ 11'($urandom_range(1, 2047));
			3: begin
				d = $urandom_range(0, 14);
				r.dlc = 4'((d >= 8) ? d + 1 : d);
			end
			default: begin
				r.frame_flags = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255));
				r.bus = 2'($urandom_range(0, 3));
				r.std_id = 11'($urandom_range(0, 2047));
				r.dlc = 4'($urandom_range(0, 15));
			end
		endcase
		return r;
	endfunction

	function automatic req_t random_snap();
		int span;
		if ($urandom_range(0, 99) < 15)
			return snap_of($urandom());
		span = int'(sb.tmo_reg) + int'(sb.tmo_reg) / 4 + 4;
		return snap_of(now_ms + $urandom_range(0, span));
	endfunction

	task automatic push_item(input req_t item);
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.data <= item;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic pause_tx(input int n);
		if (n > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic send(input req_t item);
		push_item(item);
		pause_tx(tx_gap());
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
		sb.write_reg(idx, v);
	endtask

	// frames leave no result, so let the back end settle before touching registers
	task automatic set_meter(input logic en, input logic [1:0] bus, input logic [10:0] id,
			input logic [15:0] tmo);
		wait_drained();
		repeat (12) @(posedge clk);
		write_reg(REG_ENABLE, CFG_DATA_W'(en));
		write_reg(REG_RX_BUS, CFG_DATA_W'(bus));
		write_reg(REG_RX_ID, CFG_DATA_W'(id));
		write_reg(REG_TIMEOUT, tmo);
		settings_used++;
	endtask

	task automatic random_phase(input int quota);
		int   done;
		int   pick;
		req_t r;
		done = 0;
		tx_free = ($urandom_range(0, 3) == 0);
		rx_free = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 2) == 0)
			now_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
		while (done < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				// burst long enough to overrun the ring
				repeat (QUEUE_SLOTS_DEF + 1) begin
					send(good_frame());
					done++;
				end
			end else begin
				if (pick < 48)
					r = good_frame();
				else if (pick < 60)
					r = bad_frame();
				else if (pick < 78)
					r = pop_of(LIMIT_W'($urandom_range(0, 9) < 7 ? $urandom_range(1, 5)
						: $urandom_range(0, 31)));
				else if (pick < 88)
					r = random_snap();
				else if (pick < 95)
					r = stat_of(3'($urandom_range(0, 7)));
				else
					r = noise_item();
				send(r);
				done++;
			end
			if ($urandom_range(0, 99) == 0)
				wait_drained();
		end
		tx_free = 1'b0;
		rx_free = 1'b0;
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// inactive after reset: frames vanish, empty snapshot and pops
		send(frame_of(8'd0, 2'd0, 11'd0, FRAME_DLC, 32'h1234_5678, 32'd5));
		send(snap_of(32'd0));
		send(pop_of(5'd0));
		send(pop_of(5'd16));
		send(stat_of(3'd7));

		set_meter(1'b1, 2'd3, 11'd2047, 16'hFFFF);
		send(frame_of(8'hFF, 2'd3, 11'd2047, FRAME_DLC, 32'h1, 32'd1));
		send(frame_of(8'd0, 2'd0, 11'd2047, FRAME_DLC, 32'h2, 32'd2));
		send(frame_of(8'd0, 2'd3, 11'd0, FRAME_DLC, 32'h3, 32'd3));
		send(frame_of(8'd0, 2'd3, 11'd2047, 4'd15, 32'h4, 32'd4));
		send(frame_of(8'd0, 2'd3, 11'd2047, 4'd0, 32'h5, 32'd5));
		send(frame_of(8'd0, 2'd3, 11'd2047, FRAME_DLC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send(frame_of(8'd0, 2'd3, 11'd2047, FRAME_DLC, 32'h0, 32'h0));
		send(snap_of(32'd65535));
		send(snap_of(32'd65536));
		send(snap_of(32'hFFFF_FFFF));
		send(pop_of(5'd1));
		send(pop_of(5'd31));
		for (int i = 0; i < 8; i++)
			send(stat_of(3'(i)));

		set_meter(1'b1, 2'd1, 11'd0, 16'd1);
		random_phase(45);
		set_meter(1'b1, 2'd3, 11'd2047, 16'hFFFF);
		random_phase(45);
		set_meter(1'b0, 2'd2, 11'($urandom_range(0, 2047)), 16'd500);
		random_phase(15);
		set_meter(1'b1, 2'd0, 11'($urandom_range(0, 2047)), 16'd500);
		random_phase(15);
		set_meter(1'b1, 2'd2, 11'($urandom_range(0, 2047)), 16'd0);
		random_phase(15);
		repeat (2) begin
			set_meter(1'b1, 2'($urandom_range(1, 3)), 11'($urandom_range(0, 2047)),
				16'($urandom_range(1, 3000)));
			random_phase(45);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("sent %0d items over %0d register settings; checked %0d results, %0d popped",
			items_sent, settings_used, sb.checked, sb.popped);
		$display("ring-full drops %0d, fresh snapshots %0d, rejects type/bus/id/dlc %0d/%0d/%0d/%0d",
			sb.ring_full_hits, sb.fresh_hits, sb.counts[CNT_TYPE], sb.counts[CNT_BUS],
			sb.counts[CNT_ID], sb.counts[CNT_DLC]);
		if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
